// ----- rtl/char_lcd_command_sequencer_macros.svh -----
// Assertion macros shared by the character LCD sequencer RTL.
`ifndef CHAR_LCD_COMMAND_SEQUENCER_MACROS_SVH
`define CHAR_LCD_COMMAND_SEQUENCER_MACROS_SVH
`ifndef ASSERT_OFF
// Checked on every clock edge outside of reset.
`define CLCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define CLCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLCD_ASSERT(lbl, prop, msg)
`define CLCD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/clcd_pkg.sv -----
// Shared types, codes and constant tables of the character LCD sequencer.
package clcd_pkg;

  localparam logic [2:0] CMD_RAW    = 3'd0;
  localparam logic [2:0] CMD_CHAR   = 3'd1;
  localparam logic [2:0] CMD_CURSOR = 3'd2;
  localparam logic [2:0] CMD_NUMBER = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;
  localparam logic [2:0] CMD_INIT   = 3'd5;

  localparam logic [7:0] ROW0_BASE     = 8'h80;
  localparam logic [7:0] ROW1_BASE     = 8'hC0;
  localparam logic [7:0] SPACE_CODE    = 8'h20;
  localparam logic [7:0] CLEAR_DISPLAY = 8'h01;
  localparam logic [7:0] ASCII_ZERO    = 8'h30;

  localparam logic [2:0] LAST_PLACE = 3'd4;

  // One decimal character offered by the digit unit.
  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
    logic       last;
  } clcd_dig_t;

  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h38;
      3'd1: b = 8'h02;
      3'd2: b = 8'h01;
      3'd3: b = 8'h0C;
      3'd4: b = 8'h06;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] err_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:  c = "A";
      4'd1:  c = "d";
      4'd2:  c = "d";
      4'd3:  c = "r";
      4'd4:  c = "e";
      4'd5:  c = "s";
      4'd6:  c = "s";
      4'd7:  c = " ";
      4'd8:  c = "E";
      4'd9:  c = "R";
      4'd10: c = "R";
      4'd11: c = "O";
      4'd12: c = "R";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] pow10(input logic [2:0] place);
    logic [15:0] p;
    case (place)
      3'd0: p = 16'd10000;
      3'd1: p = 16'd1000;
      3'd2: p = 16'd100;
      3'd3: p = 16'd10;
      3'd4: p = 16'd1;
      default: p = 16'd1;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/clcd_digit_unit.sv -----
// Shared compare-and-subtract unit that turns a 16-bit value into decimal characters.
module clcd_digit_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [15:0]         number,
  input  logic                take,
  output clcd_pkg::clcd_dig_t dig
);
  import clcd_pkg::*;

  logic        active_r, active_nxt;
  logic        started_r, started_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [2:0]  place_r, place_nxt;
  logic [3:0]  digit_r, digit_nxt;
  logic [15:0] weight;
  logic        ge;
  logic        show;

  assign weight = pow10(place_r);
  assign ge     = rem_r >= weight;
  // A finished digit is shown unless it is a leading zero.
  assign show   = (digit_r != 4'd0) || started_r;

  assign dig.valid = active_r && !ge && show;
  assign dig.ch    = ASCII_ZERO + {4'd0, digit_r};
  assign dig.last  = place_r == LAST_PLACE;

  always_comb begin
    active_nxt  = active_r;
    started_nxt = started_r;
    rem_nxt     = rem_r;
    place_nxt   = place_r;
    digit_nxt   = digit_r;
    if (start) begin
      active_nxt  = 1'b1;
      started_nxt = 1'b0;
      rem_nxt     = number;
      place_nxt   = 3'd0;
      digit_nxt   = 4'd0;
    end else if (active_r) begin
      if (ge) begin
        rem_nxt   = rem_r - weight;
        digit_nxt = digit_r + 4'd1;
      end else if (!show) begin
        place_nxt = place_r + 3'd1;
        digit_nxt = 4'd0;
      end else if (take) begin
        started_nxt = 1'b1;
        place_nxt   = place_r + 3'd1;
        digit_nxt   = 4'd0;
        if (place_r == LAST_PLACE) begin
          active_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      started_r <= 1'b0;
      place_r   <= 3'd0;
      digit_r   <= 4'd0;
    end else begin
      active_r  <= active_nxt;
      started_r <= started_nxt;
      place_r   <= place_nxt;
      digit_r   <= digit_nxt;
    end
    rem_r <= rem_nxt;
  end

endmodule

// ----- rtl/char_lcd_command_sequencer.sv -----
// Top level: expands one display request into a run of LCD bus writes.
//
// Usage: the in_ channel carries one display request per transaction, with the
// request kind in in_tuser and its operands packed in in_tdata. The out_
// channel carries one LCD bus write per transaction: the byte in out_tdata,
// register select in out_tuser, and out_tlast on the final write of a request.
// A request is taken only while the sequencer is idle; in_tready stays low
// until its last write has been loaded into the output register.
// A fixed-sequence request is first registered into state S_EMIT; its first write
// is then loaded into the output register. Fixed sequences (raw, character,
// cursor, clear, initialize) give one write per cycle while the receiver does
// not stall, up to 18 writes. Number printing runs through one shared
// compare-and-subtract unit, one subtraction per cycle; a digit is offered once its
// subtractions are done, and leading zeros are skipped. Requests that produce no
// write (number zero, unused codes) leave the sequencer idle.
// When the receiver stalls, the output register holds its write and the
// sequence pauses. Reset empties the output register and returns to idle.
module char_lcd_command_sequencer #(
  parameter int COLUMNS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // byte_value[7:0], row[9:8], column[17:10], number[33:18]
  input  logic [2:0]  in_tuser,   // command[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // bus_byte[7:0]
  output logic        out_tuser,  // register_select
  output logic        out_tlast
);
  import clcd_pkg::*;

  `include "char_lcd_command_sequencer_macros.svh"

  localparam int         SPACES = (COLUMNS < 16) ? COLUMNS : 16;
  localparam logic [7:0] COLS_W = 8'(COLUMNS);
  localparam logic [4:0] CLR_CNT = 5'(SPACES + 2);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMIT,
    S_DIGIT
  } state_t;

  state_t      state_r, state_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [2:0]  cmd_r, cmd_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [1:0]  row_r, row_nxt;
  logic [7:0]  col_r, col_nxt;
  logic        out_tvalid_r, out_tvalid_nxt;
  logic [7:0]  out_tdata_r, out_tdata_nxt;
  logic        out_tuser_r, out_tuser_nxt;
  logic        out_tlast_r, out_tlast_nxt;

  logic        in_acc;
  logic        slot_free;
  logic        dig_start;
  logic        dig_take;
  clcd_dig_t   dig_st;
  logic [7:0]  base;
  logic [4:0]  idx_m1;
  logic        wr_rs;
  logic [7:0]  wr_byte;
  logic [4:0]  wr_cnt;
  logic        wr_last;

  assign in_tready = state_r == S_IDLE;
  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_tvalid_r || out_tready;
  assign dig_start = in_acc && (in_tuser == CMD_NUMBER) && (in_tdata[33:18] != 16'd0);
  assign dig_take  = (state_r == S_DIGIT) && dig_st.valid && slot_free;

  clcd_digit_unit u_digit (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (dig_start),
    .number (in_tdata[33:18]),
    .take   (dig_take),
    .dig    (dig_st)
  );

  assign base   = row_r[0] ? ROW1_BASE : ROW0_BASE;
  assign idx_m1 = idx_r - 5'd1;

  // Write number idx_r of the current fixed sequence and the sequence length.
  always_comb begin
    wr_rs   = 1'b0;
    wr_byte = 8'h00;
    wr_cnt  = 5'd1;
    case (cmd_r)
      CMD_RAW: begin
        wr_byte = byte_r;
      end
      CMD_CHAR: begin
        wr_rs   = 1'b1;
        wr_byte = byte_r;
      end
      CMD_CURSOR: begin
        if (!row_r[1]) begin
          if (col_r < COLS_W) begin
            wr_byte = base + col_r;
          end else begin
            wr_cnt = 5'd14;
            if (idx_r == 5'd0) begin
              wr_byte = base;
            end else begin
              wr_rs   = 1'b1;
              wr_byte = err_char(idx_m1[3:0]);
            end
          end
        end else begin
          wr_cnt  = 5'd13;
          wr_rs   = 1'b1;
          wr_byte = err_char(idx_r[3:0]);
        end
      end
      CMD_CLEAR: begin
        if (!row_r[1]) begin
          wr_cnt = CLR_CNT;
          if (idx_r == 5'd0 || idx_r == CLR_CNT - 5'd1) begin
            wr_byte = base;
          end else begin
            wr_rs   = 1'b1;
            wr_byte = SPACE_CODE;
          end
        end else begin
          wr_byte = CLEAR_DISPLAY;
        end
      end
      CMD_INIT: begin
        wr_cnt  = 5'd5;
        wr_byte = init_byte(idx_r[2:0]);
      end
      default: begin
        wr_cnt = 5'd1;
      end
    endcase
    wr_last = idx_r == wr_cnt - 5'd1;
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    cmd_nxt        = cmd_r;
    byte_nxt       = byte_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    out_tlast_nxt  = out_tlast_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt  = in_tuser;
          byte_nxt = in_tdata[7:0];
          row_nxt  = in_tdata[9:8];
          col_nxt  = in_tdata[17:10];
          idx_nxt  = 5'd0;
          case (in_tuser)
            CMD_RAW, CMD_CHAR, CMD_CURSOR, CMD_CLEAR, CMD_INIT: state_nxt = S_EMIT;
            CMD_NUMBER: state_nxt = dig_start ? S_DIGIT : S_IDLE;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = wr_byte;
          out_tuser_nxt  = wr_rs;
          out_tlast_nxt  = wr_last;
          idx_nxt        = idx_r + 5'd1;
          if (wr_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DIGIT: begin
        if (dig_take) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = dig_st.ch;
          out_tuser_nxt  = 1'b1;
          out_tlast_nxt  = dig_st.last;
          if (dig_st.last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= 5'd0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    cmd_r       <= cmd_nxt;
    byte_r      <= byte_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  `CLCD_ASSERT(a_digit_ascii,
    dig_st.valid |-> (dig_st.ch[7:4] == 4'h3 && dig_st.ch[3:0] <= 4'd9),
    "digit unit offered a character that is not a decimal digit")
  `CLCD_ASSERT(a_number_starts,
    dig_start |=> (state_r == S_DIGIT),
    "nonzero number request did not enter digit printing")
  `CLCD_ASSERT(a_last_frees,
    (state_r == S_EMIT && slot_free && wr_last) |=> (state_r == S_IDLE && out_tlast),
    "final write of a sequence did not return the sequencer to idle")
  `CLCD_ASSERT(a_digit_last_frees,
    (dig_take && dig_st.last) |=> (state_r == S_IDLE && out_tlast && out_tuser),
    "final digit did not end the number request")

endmodule
